// ----- rtl/assert_macros.svh -----
// Assertion macros used by the datapath of the factor histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define TSFG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tsfg assertion failed");
// Condition must never be true outside reset.
`define TSFG_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tsfg forbidden condition seen");
`else
`define TSFG_ASSERT(lbl, clk, rst_n, prop)
`define TSFG_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/tsfg_pkg.sv -----
// Package with the shared types and constants of the factor histogram block.
`default_nettype none
package tsfg_pkg;
    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FIRST_DIVISOR  = 2;

    typedef enum logic [1:0] {
        KIND_ADD_A = 2'd0,
        KIND_ADD_B = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_CHECK,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_LEFT_RD,
        ST_LEFT_WR,
        ST_Q_RD,
        ST_Q_OUT
    } t_state;

    typedef struct packed {
        logic load_item;   // capture operand, restart the divisor sweep
        logic set_b;       // item targets set B
        logic clr_init;    // restart the clearing sweep
        logic clr_step;    // zero one entry of both histograms
        logic div_start;   // begin a division of the remaining value by d
        logic div_step;    // one restoring division step
        logic rest_update; // divisor went in evenly: keep quotient, count it
        logic next_div;    // move on to the next divisor
        logic addr_rest;   // memory address is the remaining value, not d
        logic mem_wr;      // write back the saturated count
        logic amount_one;  // add one instead of the exponent
        logic out_load;    // load the query result register
    } t_cmd;

    typedef struct packed {
        logic sq_gt_rest;
        logic rest_gt1;
        logic rem_zero;
        logic exp_nz;
        logic div_last;
        logic clr_last;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

// ----- rtl/tsfg_ctrl.sv -----
// Controller state machine of the factor histogram block.
`default_nettype none
module tsfg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_kind,
    input  tsfg_pkg::t_status i_status,
    output tsfg_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);
    import tsfg_pkg::*;

    t_state r_state, n_state;
    t_kind  kind;

    assign kind       = t_kind'(i_kind);
    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (kind)
                        KIND_ADD_A, KIND_ADD_B: begin
                            o_cmd.load_item = 1'b1;
                            o_cmd.set_b     = (kind == KIND_ADD_B);
                            n_state         = ST_TEST;
                        end
                        KIND_QUERY: begin
                            o_cmd.load_item = 1'b1;
                            n_state         = ST_Q_RD;
                        end
                        default: begin
                            o_cmd.clr_init = 1'b1;
                            n_state        = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_TEST: begin
                if (i_status.sq_gt_rest) begin
                    n_state = i_status.rest_gt1 ? ST_LEFT_RD : ST_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.rem_zero) begin
                    o_cmd.rest_update = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    n_state           = ST_DIV;
                end else if (i_status.exp_nz) begin
                    n_state = ST_BUMP_RD;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = ST_TEST;
                end
            end
            ST_BUMP_RD: begin
                n_state = ST_BUMP_WR;
            end
            ST_BUMP_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.next_div = 1'b1;
                n_state        = ST_TEST;
            end
            ST_LEFT_RD: begin
                o_cmd.addr_rest = 1'b1;
                n_state         = ST_LEFT_WR;
            end
            ST_LEFT_WR: begin
                o_cmd.addr_rest  = 1'b1;
                o_cmd.mem_wr     = 1'b1;
                o_cmd.amount_one = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_Q_RD: begin
                o_cmd.addr_rest = 1'b1;
                n_state         = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                o_cmd.addr_rest = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/tsfg_dp.sv -----
// Datapath: divisor sweep, restoring divider, count memories, result register.
`default_nettype none
`include "assert_macros.svh"
module tsfg_dp #(
    parameter int VALUE_BITS = tsfg_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = tsfg_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_operand_value,
    input  tsfg_pkg::t_cmd    i_cmd,
    output tsfg_pkg::t_status o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [15:0]       o_queried_index,
    output logic [15:0]       o_common_count,
    output logic              o_saturated
);
    import tsfg_pkg::*;

    localparam int DEPTH = 1 << VALUE_BITS;
    localparam int D_W   = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int EXP_W = $clog2(VALUE_BITS + 1);
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int SUM_W = ((COUNT_BITS > EXP_W) ? COUNT_BITS : EXP_W) + 1;
    localparam int MW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem_a [DEPTH];
    logic [COUNT_BITS-1:0] mem_b [DEPTH];

    logic [VALUE_BITS-1:0] r_rest, r_quo, r_clr;
    logic [D_W-1:0]        r_d, r_rem, n_rem;
    logic [SQ_W-1:0]       r_sq;
    logic [EXP_W-1:0]      r_exp;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_set_b, r_ovalid;
    logic [COUNT_BITS-1:0] r_rd_a, r_rd_b;
    logic [15:0]           r_oidx, r_ocount;
    logic                  r_osat;

    logic [D_W:0]            rem_sh, d_ext;
    logic                    ge;
    logic [VALUE_BITS-1:0]   addr;
    logic [COUNT_BITS-1:0]   cur, wdata, cmin;
    logic [SUM_W-1:0]        amt, sum;
    logic [MW-1:0]           m_ext;

    // Restoring division step of the remaining value by the divisor.
    assign rem_sh = {r_rem, r_quo[VALUE_BITS-1]};
    assign d_ext  = {1'b0, r_d};
    assign ge     = (rem_sh >= d_ext);
    assign n_rem  = ge ? D_W'(rem_sh - d_ext) : D_W'(rem_sh);

    assign addr  = i_cmd.addr_rest ? r_rest : VALUE_BITS'(r_d);
    assign cur   = r_set_b ? r_rd_b : r_rd_a;
    assign amt   = i_cmd.amount_one ? SUM_W'(1) : SUM_W'(r_exp);
    assign sum   = SUM_W'(cur) + amt;
    assign wdata = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sum);

    assign cmin  = (r_rd_a < r_rd_b) ? r_rd_a : r_rd_b;
    assign m_ext = MW'(cmin);

    assign o_status.sq_gt_rest = (r_sq > SQ_W'(r_rest));
    assign o_status.rest_gt1   = (r_rest > VALUE_BITS'(1));
    assign o_status.rem_zero   = (r_rem == '0);
    assign o_status.exp_nz     = (r_exp != '0);
    assign o_status.div_last   = (r_cnt == CNT_W'(VALUE_BITS - 1));
    assign o_status.clr_last   = (r_clr == '1);
    assign o_status.out_free   = !r_ovalid || !i_out_stall;

    assign o_out_valid     = r_ovalid;
    assign o_queried_index = r_oidx;
    assign o_common_count  = r_ocount;
    assign o_saturated     = r_osat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_a[r_clr] <= '0;
            mem_b[r_clr] <= '0;
        end else if (i_cmd.mem_wr) begin
            if (r_set_b) begin
                mem_b[addr] <= wdata;
            end else begin
                mem_a[addr] <= wdata;
            end
        end
        r_rd_a <= mem_a[addr];
        r_rd_b <= mem_b[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_clr    <= '0;
        end else begin
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.clr_init) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + VALUE_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rest  <= VALUE_BITS'(i_operand_value);
            r_set_b <= i_cmd.set_b;
            r_d     <= D_W'(FIRST_DIVISOR);
            r_sq    <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
            r_exp   <= '0;
        end
        if (i_cmd.rest_update) begin
            r_rest <= r_quo;
            r_exp  <= r_exp + EXP_W'(1);
        end
        if (i_cmd.next_div) begin
            r_d   <= r_d + D_W'(1);
            r_sq  <= r_sq + SQ_W'({r_d, 1'b0}) + SQ_W'(1);
            r_exp <= '0;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= '0;
            if (!i_cmd.rest_update) begin
                r_quo <= r_rest;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[VALUE_BITS-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_oidx   <= 16'(r_rest);
            r_ocount <= (m_ext > MW'(16'hFFFF)) ? 16'hFFFF : 16'(m_ext);
            r_osat   <= (r_rd_a == COUNT_MAX) || (r_rd_b == COUNT_MAX);
        end
    end

    `TSFG_ASSERT(a_rem_below_d, i_clk, i_rst_n, i_cmd.div_step |-> (r_rem < r_d))
    `TSFG_ASSERT(a_div_by_two_up, i_clk, i_rst_n, i_cmd.div_step |-> (r_d >= D_W'(FIRST_DIVISOR)))
    `TSFG_ASSERT(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load |-> (!r_ovalid || !i_out_stall))
    `TSFG_NEVER(a_no_wr_in_clear, i_clk, i_rst_n, i_cmd.clr_step && i_cmd.mem_wr)
endmodule
`default_nettype wire

// ----- rtl/two_set_factor_gcd_core.sv -----
// Top level of the two-set factor histogram block with GCD exponent query.
//
//  Channel  Direction  Handshake               Payload
//  input    in         i_in_valid/o_in_stall   i_kind, i_operand_value
//  result   out        o_out_valid/i_out_stall o_queried_index, o_common_count, o_saturated
//
// An added number is factored by trial division. Each divisor tried takes a
// square test, then a restoring division over all VALUE_BITS bits of the
// remaining value and a check, and every prime found takes a read-modify-write
// of its count. A query reads both count memories, then loads the result
// register once it is free; a clear sweeps all 2^VALUE_BITS entries of both
// count memories.
// After reset the same clearing sweep runs and o_in_stall stays high meanwhile.
// One request is worked on at a time; a finished query result waits in the
// output register while the next request is taken, and only a second query
// result waits for it to drain.
`default_nettype none
module two_set_factor_gcd_core #(
    parameter int VALUE_BITS = tsfg_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = tsfg_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_queried_index,
    output logic [15:0] o_common_count,
    output logic        o_saturated
);
    import tsfg_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    t_cmd    cmd;
    t_status status;

    tsfg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds both count memories and the query result register.
    tsfg_dp #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operand_value (i_operand_value),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_queried_index (o_queried_index),
        .o_common_count  (o_common_count),
        .o_saturated     (o_saturated)
    );
endmodule
`default_nettype wire

// ----- tb/tb_two_set_factor_gcd_core.sv -----
// Self-checking testbench for the two-set factor histogram core with GCD exponent query.
`timescale 1ns / 1ps
`default_nettype none
module tb_two_set_factor_gcd_core;
    import tsfg_pkg::*;

    localparam int CNT_MAX      = 65535;
    localparam int DRAIN_CYCLES = 5000;       // room for the longest add to finish
    localparam int CYCLE_LIMIT  = 30_000_000; // every request a slowest add, plus clears, taken wide

    // Expected result of one query.
    typedef struct {
        logic [15:0] index;
        logic [15:0] common;
        logic        sat;
    } t_query_result;

    // Mirror of both exponent histograms plus the queue of pending query results.
    // Associative arrays keep the clears cheap: a missing entry counts as zero.
    class gcd_scoreboard;
        int unsigned   hist_a[int unsigned];
        int unsigned   hist_b[int unsigned];
        t_query_result pending[$];
        int            errors;
        int            queries_seen;

        function int unsigned lookup(ref int unsigned h[int unsigned], input int unsigned idx);
            return h.exists(idx) ? h[idx] : 0;
        endfunction

        function void bump(bit set_b, int unsigned idx, int unsigned amount);
            int unsigned cur;
            int unsigned sum;
            cur = set_b ? lookup(hist_b, idx) : lookup(hist_a, idx);
            sum = cur + amount;
            if (sum > CNT_MAX) sum = CNT_MAX;
            if (set_b) hist_b[idx] = sum;
            else hist_a[idx] = sum;
        endfunction

        // Trial division: each divisor that goes in evenly adds its exponent,
        // and whatever is left above one adds a single count at its own index.
        function void factor(bit set_b, int unsigned value);
            int unsigned rest;
            int unsigned d;
            int unsigned ex;
            rest = value;
            for (d = 2; d * d <= rest; d++) begin
                if (rest % d == 0) begin
                    ex = 0;
                    while (rest % d == 0) begin
                        rest = rest / d;
                        ex++;
                    end
                    bump(set_b, d, ex);
                end
            end
            if (rest > 1) bump(set_b, rest, 1);
        endfunction

        function void note_request(t_kind kind, logic [15:0] operand);
            t_query_result r;
            int unsigned a;
            int unsigned b;
            case (kind)
                KIND_ADD_A: factor(1'b0, operand);
                KIND_ADD_B: factor(1'b1, operand);
                KIND_CLEAR: begin
                    hist_a.delete();
                    hist_b.delete();
                end
                default: begin
                    a = lookup(hist_a, operand);
                    b = lookup(hist_b, operand);
                    r.index  = operand;
                    r.common = 16'((a < b) ? a : b);
                    r.sat    = (a == CNT_MAX) || (b == CNT_MAX);
                    pending.push_back(r);
                end
            endcase
        endfunction

        function void check_result(logic [15:0] index, logic [15:0] common, logic sat);
            t_query_result e;
            if (pending.size() == 0) begin
                $error("query result with none expected: index %0d", index);
                errors++;
                return;
            end
            e = pending.pop_front();
            queries_seen++;
            if (index !== e.index) begin
                $error("queried_index: expected %0d, got %0d", e.index, index);
                errors++;
            end
            if (common !== e.common) begin
                $error("common_count: expected %0d, got %0d", e.common, common);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0d, got %0d", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [15:0] i_operand_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_queried_index;
    logic [15:0] o_common_count;
    logic        o_saturated;

    gcd_scoreboard sb;
    int            cycle_count;
    int            requests_sent;
    int            clears_sent;
    int            stall_mode;

    two_set_factor_gcd_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_queried_index (o_queried_index),
        .o_common_count  (o_common_count),
        .o_saturated     (o_saturated)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Cycle counter and watchdog. A run that hangs is a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: the stall pattern is drawn at random among no stall,
    // light stall and heavy stall, so back-pressure lands on every phase of a query.
    always @(posedge i_clk) begin
        if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 25);
            default: i_out_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    // Sampled at the clock edge, before the core's own updates land, so the
    // values seen are exactly those that took part in the handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_queried_index, o_common_count, o_saturated);
    end

    // Idle cycles between requests: mostly none or a few, now and then a long pause.
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 80);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Presents one request and holds it until the core accepts it. The stall is
    // looked at mid-cycle, where it is stable for the coming edge.
    task automatic send_request(t_kind kind, logic [15:0] operand);
        bit taken;
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_operand_value <= operand;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_request(kind, operand);
        requests_sent++;
        if (kind == KIND_CLEAR) clears_sent++;
    endtask

    // Operand for an add: mostly small numbers so the trial division stays short,
    // sometimes full-range values and large primes, which take the longest.
    function automatic logic [15:0] pick_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 16'($urandom_range(0, 255));
        if (r < 80) return 16'($urandom_range(0, 4095));
        if (r < 85) return 16'd32768 >> $urandom_range(0, 15);
        if (r < 90) return (r < 88) ? 16'd65521 : 16'd65519;
        return 16'($urandom);
    endfunction

    // Index for a query: often small values from 2 to 13 that adds hit often, else anything.
    function automatic logic [15:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(2, 13));
        if (r < 80) return 16'($urandom_range(0, 255));
        return 16'($urandom);
    endfunction

    initial begin
        sb = new();
        cycle_count     = 0;
        requests_sent   = 0;
        clears_sent     = 0;
        stall_mode      = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_kind          = KIND_ADD_A;
        i_operand_value = 16'd0;
        i_out_stall     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: zero and one add nothing, the extremes of the operand,
        // a large prime left over after division, powers of two, queries, a clear and more queries.
        send_request(KIND_ADD_A, 16'd0);
        send_request(KIND_ADD_B, 16'd1);
        send_request(KIND_ADD_A, 16'hFFFF);
        send_request(KIND_ADD_B, 16'hFFFF);
        send_request(KIND_ADD_A, 16'd65521);
        send_request(KIND_ADD_B, 16'd65521);
        send_request(KIND_ADD_A, 16'd32768);
        send_request(KIND_ADD_B, 16'd4096);
        send_request(KIND_ADD_A, 16'd2);
        send_request(KIND_ADD_B, 16'd30030);
        send_request(KIND_QUERY, 16'd0);
        send_request(KIND_QUERY, 16'd1);
        send_request(KIND_QUERY, 16'd2);
        send_request(KIND_QUERY, 16'd3);
        send_request(KIND_QUERY, 16'd5);
        send_request(KIND_QUERY, 16'd257);
        send_request(KIND_QUERY, 16'd65521);
        send_request(KIND_QUERY, 16'hFFFF);
        send_request(KIND_CLEAR, 16'hFFFF);
        send_request(KIND_QUERY, 16'd2);
        send_request(KIND_QUERY, 16'd65521);

        // Random part. Clears are rare because each one sweeps the whole memory.
        for (int i = 0; i < 1150; i++) begin
            int r;
            idle_gap();
            r = $urandom_range(0, 99);
            if (i == 380 || i == 760 || i == 1100)
                send_request(KIND_CLEAR, 16'($urandom));
            else if (r < 36)
                send_request(KIND_ADD_A, pick_number());
            else if (r < 72)
                send_request(KIND_ADD_B, pick_number());
            else
                send_request(KIND_QUERY, pick_index());
        end
        i_in_valid <= 1'b0;

        // Drain: every query answered, then time for a trailing add to finish.
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d clears), checked %0d query results in %0d cycles.",
                 requests_sent, clears_sent, sb.queries_seen, cycle_count);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
